/* rtl/smp_pkg.sv */
// Shared constants, types and functions of the serial mouse port.
package smp_pkg;

  localparam int unsigned PACKET_BITS = 32;
  localparam int unsigned CUR_W = $clog2(PACKET_BITS + 1);
  localparam int unsigned PORTS = 2;
  localparam int unsigned PORT_W = $clog2(PORTS);
  localparam int unsigned CFG_AW = 3;

  localparam logic [1:0] MODE_SUBMIT = 2'd0;
  localparam logic [1:0] MODE_LATCH = 2'd1;
  localparam logic [1:0] MODE_READ = 2'd2;

  localparam logic [0:0] REG_PORT0 = 1'b0;
  localparam logic [0:0] REG_PORT1 = 1'b1;

  localparam logic [1:0] SPEED_SLOW = 2'd0;
  localparam logic [1:0] SPEED_MID = 2'd1;
  localparam logic [1:0] SPEED_FAST = 2'd2;

  localparam logic signed [31:0] AXIS_MAX = 32'sd127;
  localparam logic [7:0] LEFT_MASK = 8'h40;
  localparam logic [7:0] RIGHT_MASK = 8'h80;

  localparam logic [6:0] ACCEL_MID [8] = '{7'd0, 7'd1, 7'd2, 7'd3, 7'd8, 7'd10, 7'd12, 7'd21};
  localparam logic [6:0] ACCEL_FAST [8] = '{7'd0, 7'd1, 7'd4, 7'd9, 7'd12, 7'd20, 7'd24, 7'd28};

  typedef struct packed {
    logic signed [31:0]       pend_dx;
    logic signed [31:0]       pend_dy;
    logic                     sign_x;
    logic                     sign_y;
    logic [1:0]               speed;
    logic [1:0]               buttons;
    logic [PACKET_BITS-1:0]   packet;
    logic [CUR_W-1:0]         cursor;
  } row_t;

  typedef struct packed {
    logic                cap0;
    logic                cap;
    logic [1:0]          mode;
    logic [PORT_W-1:0]   port;
    logic [1:0]          buttons;
    logic signed [31:0]  dx;
    logic signed [31:0]  dy;
    logic                latched;
  } op_t;

  typedef struct packed {
    logic signed [31:0]  pend;
    logic                neg;
    logic [7:0]          byte_v;
  } axis_res_t;

  function automatic logic signed [31:0] sat_add(input logic signed [31:0] a,
                                                 input logic signed [31:0] b);
    logic [32:0] s;
    s = {a[31], a} + {b[31], b};
    if (s[32] != s[31]) begin
      sat_add = s[32] ? {1'b1, 31'b0} : {1'b0, {31{1'b1}}};
    end else begin
      sat_add = s[31:0];
    end
  endfunction

  function automatic logic [6:0] accel_map(input logic [1:0] spd, input logic [6:0] mag);
    logic [2:0] idx;
    idx = (mag < 7'd7) ? mag[2:0] : 3'd7;
    case (spd)
      SPEED_MID: accel_map = ACCEL_MID[idx];
      SPEED_FAST: accel_map = ACCEL_FAST[idx];
      default: accel_map = mag;
    endcase
  endfunction

  function automatic axis_res_t axis_step(input logic signed [31:0] pend, input logic neg,
                                          input logic [1:0] spd);
    logic signed [31:0] d;
    logic signed [31:0] dabs;
    logic [6:0] mag;
    axis_res_t r;
    if (pend < -AXIS_MAX) begin
      d = -AXIS_MAX;
    end else if (pend > AXIS_MAX) begin
      d = AXIS_MAX;
    end else begin
      d = pend;
    end
    r.pend = pend - d;
    r.neg = (d != 32'sd0) ? d[31] : neg;
    dabs = d[31] ? -d : d;
    mag = accel_map(spd, dabs[6:0]);
    r.byte_v = {r.neg, mag};
    axis_step = r;
  endfunction

endpackage

/* rtl/smp_ifs.sv */
// Request and result channel interfaces of the serial mouse port.
interface smp_in_if;
  logic                valid;
  logic                ready;
  logic [1:0]          mode;
  logic                port_sel;
  logic [1:0]          button_bits;
  logic signed [31:0]  delta_x;
  logic signed [31:0]  delta_y;
  logic                latch_level;

  modport source (output valid, mode, port_sel, button_bits, delta_x, delta_y, latch_level,
                  input ready);
  modport sink (input valid, mode, port_sel, button_bits, delta_x, delta_y, latch_level,
                output ready);
endinterface

interface smp_out_if;
  logic valid;
  logic ready;
  logic data_bit;

  modport source (output valid, data_bit, input ready);
  modport sink (input valid, data_bit, output ready);
endinterface

/* rtl/serial_mouse_port.sv */
// Serial mouse port top level: two port rows in a small state memory.
//
// Two controller ports, each with a mouse or nothing (APB registers at byte
// address 0 and 4, bit 0). A request is accepted every cycle unless output
// stalls or a capture is under way, and gives one result bit via the stage
// register and an output register. A latch request that makes the latch
// line fall captures a packet on both ports: it passes the read-modify-write
// stage once per port row, port 0 then port 1, holding off the next request.
// The per-port state lives in a two-row memory with a registered read; a row
// written back in the cycle it is read again is forwarded. Changing a port's
// device register clears that port's row at once (no clearing pass).
// Configuration must be written only while the block is idle (not enforced).
module serial_mouse_port (
  input  logic                         clk,
  input  logic                         rst_n,
  smp_in_if.sink                       in_if,
  smp_out_if.source                    out_if,
  input  logic                         cfg_psel,
  input  logic                         cfg_penable,
  input  logic                         cfg_pwrite,
  input  logic [smp_pkg::CFG_AW-1:0]   cfg_paddr,
  input  logic [31:0]                  cfg_pwdata,
  output logic [31:0]                  cfg_prdata,
  output logic                         cfg_pready
);

  localparam logic [smp_pkg::CUR_W-1:0] CUR_LIMIT = smp_pkg::CUR_W'(smp_pkg::PACKET_BITS);

  logic [smp_pkg::PORTS-1:0]   has_mouse_r;
  logic                        latch_r;
  logic                        s1_valid_r;
  logic                        s1_valid_nxt;
  smp_pkg::op_t                s1_r;
  smp_pkg::op_t                s1_nxt;
  smp_pkg::row_t               rd_r;
  smp_pkg::row_t               mem [smp_pkg::PORTS];
  logic [smp_pkg::PORTS-1:0]   vld_r;
  logic                        out_valid_r;
  logic                        out_valid_nxt;
  logic                        out_bit_r;

  logic                        advance;
  logic                        accept;
  logic                        falling;
  logic                        load_cap1;
  logic                        s1_load;
  logic [smp_pkg::PORT_W-1:0]  rd_addr;
  logic                        we;
  logic [smp_pkg::PORT_W-1:0]  wr_addr;
  smp_pkg::row_t               wr_row;
  logic                        res_bit;
  logic                        out_emit;
  smp_pkg::axis_res_t          ax;
  smp_pkg::axis_res_t          ay;
  logic [7:0]                  hdr;
  logic                        cfg_wr;
  logic                        cfg_hit;
  logic [0:0]                  cfg_idx;
  logic [4:0]                  bit_idx;

  assign cfg_pready = 1'b1;
  assign cfg_wr = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign cfg_hit = (cfg_paddr[1:0] == 2'b00);
  assign cfg_idx = cfg_paddr[2];
  assign cfg_prdata = cfg_hit ? {31'b0, has_mouse_r[cfg_idx]} : 32'b0;

  assign out_if.valid = out_valid_r;
  assign out_if.data_bit = out_bit_r;

  always_comb begin
    advance = !s1_valid_r || s1_r.cap0 || !out_valid_r || out_if.ready;
    in_if.ready = advance && !(s1_valid_r && s1_r.cap0);
    accept = in_if.valid && in_if.ready;
    falling = (in_if.mode == smp_pkg::MODE_LATCH) && latch_r && !in_if.latch_level;
    load_cap1 = s1_valid_r && s1_r.cap0;
    s1_load = load_cap1 || accept;
    if (load_cap1) begin
      s1_nxt = s1_r;
      s1_nxt.cap0 = 1'b0;
      s1_nxt.port = 1'b1;
    end else begin
      s1_nxt.cap0 = falling;
      s1_nxt.cap = falling;
      s1_nxt.mode = in_if.mode;
      s1_nxt.port = falling ? 1'b0 : in_if.port_sel;
      s1_nxt.buttons = in_if.button_bits;
      s1_nxt.dx = in_if.delta_x;
      s1_nxt.dy = in_if.delta_y;
      s1_nxt.latched = latch_r;
    end
    rd_addr = s1_nxt.port;
    s1_valid_nxt = advance ? s1_load : s1_valid_r;
    we = s1_valid_r && advance;
    wr_addr = s1_r.port;
    out_emit = s1_valid_r && advance && !s1_r.cap0;
    out_valid_nxt = out_emit || (out_valid_r && !out_if.ready);
  end

  always_comb begin
    wr_row = rd_r;
    res_bit = 1'b0;
    ax = smp_pkg::axis_step(rd_r.pend_dx, rd_r.sign_x, rd_r.speed);
    ay = smp_pkg::axis_step(rd_r.pend_dy, rd_r.sign_y, rd_r.speed);
    hdr = 8'h01 | {2'b00, rd_r.speed, 4'h0}
        | (rd_r.buttons[0] ? smp_pkg::LEFT_MASK : 8'h00)
        | (rd_r.buttons[1] ? smp_pkg::RIGHT_MASK : 8'h00);
    bit_idx = 5'(smp_pkg::PACKET_BITS - 1) - rd_r.cursor[4:0];
    if (s1_r.cap) begin
      wr_row.cursor = '0;
      if (has_mouse_r[s1_r.port]) begin
        wr_row.pend_dx = ax.pend;
        wr_row.sign_x = ax.neg;
        wr_row.pend_dy = ay.pend;
        wr_row.sign_y = ay.neg;
        wr_row.packet = {8'h00, hdr, ay.byte_v, ax.byte_v};
      end else begin
        wr_row.packet = '0;
      end
    end else begin
      case (s1_r.mode)
        smp_pkg::MODE_SUBMIT: begin
          wr_row.buttons = s1_r.buttons;
          wr_row.pend_dx = smp_pkg::sat_add(rd_r.pend_dx, s1_r.dx);
          wr_row.pend_dy = smp_pkg::sat_add(rd_r.pend_dy, s1_r.dy);
        end
        smp_pkg::MODE_READ: begin
          if (has_mouse_r[s1_r.port]) begin
            if (s1_r.latched) begin
              wr_row.speed = (rd_r.speed >= smp_pkg::SPEED_FAST) ? smp_pkg::SPEED_SLOW
                                                                 : rd_r.speed + 2'd1;
            end else if (rd_r.cursor >= CUR_LIMIT) begin
              res_bit = 1'b1;
            end else begin
              res_bit = rd_r.packet[bit_idx];
              wr_row.cursor = rd_r.cursor + smp_pkg::CUR_W'(1);
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      has_mouse_r <= '0;
      latch_r <= 1'b0;
      s1_valid_r <= 1'b0;
      vld_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
      if (accept && in_if.mode == smp_pkg::MODE_LATCH) begin
        latch_r <= in_if.latch_level;
      end
      if (we) begin
        vld_r[wr_addr] <= 1'b1;
      end
      if (cfg_wr && cfg_hit) begin
        has_mouse_r[cfg_idx] <= cfg_pwdata[0];
        if (cfg_pwdata[0] != has_mouse_r[cfg_idx]) begin
          vld_r[cfg_idx] <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance && s1_load) begin
      s1_r <= s1_nxt;
    end
    if (out_emit) begin
      out_bit_r <= res_bit;
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wr_addr] <= wr_row;
    end
    if (advance && s1_load) begin
      if (we && wr_addr == rd_addr) begin
        rd_r <= wr_row;
      end else if (vld_r[rd_addr]) begin
        rd_r <= mem[rd_addr];
      end else begin
        rd_r <= '0;
      end
    end
  end

`ifndef ASSERT_OFF
  a_cap_pair: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && s1_r.cap0 |=> s1_valid_r && s1_r.cap && !s1_r.cap0 && s1_r.port == 1'b1)
    else $error("capture of port 0 not followed by port 1");

  a_cap_block: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && s1_r.cap0 |-> !in_if.ready)
    else $error("request taken during two-row capture");

  a_cursor_range: assert property (@(posedge clk) disable iff (!rst_n)
    we |-> wr_row.cursor <= CUR_LIMIT)
    else $error("bit cursor beyond packet");

  a_out_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(s1_valid_r) && !$past(s1_r.cap0))
    else $error("result without a finished request");
`endif

endmodule
